// ===== rtl/core/hlcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the header/length command deframer.
// No dependencies; imported by every module of the block.

package hlcd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_CMP_W  = 9;   // payload length plus header, up to 259
    localparam int OUT_FLD_W  = 3 + 4 * BYTE_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    localparam int HDR_BYTES  = 4;   // start, start, type, length
    localparam int CMD_POS    = 4;   // command type byte
    localparam int ARG_LAST   = 7;   // last stored argument byte

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FIRST  = 3'd0,
        CFG_START_SECOND = 3'd1,
        CFG_DTYPE_CMD    = 3'd2,
        CFG_DTYPE_STR    = 3'd3,
        CFG_CTYPE_MOTOR  = 3'd4,
        CFG_CTYPE_SERVO  = 3'd5,
        CFG_CTYPE_LAMP   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OC_MOTOR    = 3'd0,
        OC_SERVO    = 3'd1,
        OC_LAMP     = 3'd2,
        OC_UNKNOWN  = 3'd3,
        OC_OTHER    = 3'd4,
        OC_STRING   = 3'd5,
        OC_HDR_BAD  = 3'd6,
        OC_OVERFLOW = 3'd7
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HDR1 = 3'b010,
        ST_HDR2 = 3'b100
    } t_stage;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] cmd_dtype;
        logic [BYTE_W-1:0] dtype_string;
        logic [BYTE_W-1:0] motor_ctype;
        logic [BYTE_W-1:0] servo_ctype;
        logic [BYTE_W-1:0] ctype_lamp;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] third_arg;
        logic [BYTE_W-1:0] second_arg;
        logic [BYTE_W-1:0] first_arg;
        logic [BYTE_W-1:0] command_type;
        t_outcome          outcome;
    } t_result;

endpackage

// ===== rtl/core/hlcd_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank of the deframer: header, type and command codes.
// Depends on hlcd_pkg.

module hlcd_cfg
    import hlcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_FIRST:  r_cfg.start_first   <= i_cfg_data;
                CFG_START_SECOND: r_cfg.start_second  <= i_cfg_data;
                CFG_DTYPE_CMD:    r_cfg.cmd_dtype     <= i_cfg_data;
                CFG_DTYPE_STR:    r_cfg.dtype_string  <= i_cfg_data;
                CFG_CTYPE_MOTOR:  r_cfg.motor_ctype   <= i_cfg_data;
                CFG_CTYPE_SERVO:  r_cfg.servo_ctype   <= i_cfg_data;
                CFG_CTYPE_LAMP:   r_cfg.ctype_lamp    <= i_cfg_data;
                default: ;   // no register here: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/hlcd_parse.sv =====
`timescale 1ns / 1ps
// Frame tracker of the deframer: byte index, header stage, type, length,
// stored command bytes, and the result for the byte being consumed.
// Depends on hlcd_pkg.

module hlcd_parse
    import hlcd_pkg::*;
#(
    parameter int MAX_PACKET = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam int IDX_W = $clog2(MAX_PACKET + 1);

    logic [IDX_W-1:0]  r_idx,   n_idx;
    t_stage            r_stage, n_stage;
    logic [BYTE_W-1:0] r_dtype, n_dtype;
    logic [BYTE_W-1:0] r_len,   n_len;
    logic [BYTE_W-1:0] r_pkt [CMD_POS:ARG_LAST];
    logic [BYTE_W-1:0] n_pkt [CMD_POS:ARG_LAST];

    logic [IDX_W-1:0] w_idx;
    logic             w_done;
    t_result          w_res;

    assign w_idx = r_idx + IDX_W'(1);
    // frame is complete once index reaches length plus header
    assign w_done = !(w_idx < IDX_W'(CMD_POS + 1))
                 && !((LEN_CMP_W'(r_len) + LEN_CMP_W'(HDR_BYTES)) > LEN_CMP_W'(w_idx));

    always_comb begin
        for (int k = CMD_POS; k <= ARG_LAST; k++) begin
            n_pkt[k] = (r_idx == IDX_W'(k)) ? i_byte : r_pkt[k];
        end
    end

    always_comb begin
        n_idx       = w_idx;
        n_stage     = r_stage;
        n_dtype     = r_dtype;
        n_len       = r_len;
        o_res_valid = 1'b0;
        w_res       = '0;
        priority if (w_idx >= IDX_W'(MAX_PACKET)) begin
            n_idx         = '0;
            n_stage       = ST_IDLE;
            o_res_valid   = 1'b1;
            w_res.outcome = OC_OVERFLOW;
        end else if (w_idx == IDX_W'(1)) begin
            if (i_byte == i_cfg.start_first) begin
                n_stage = ST_HDR1;
            end else begin
                n_idx         = '0;
                n_stage       = ST_IDLE;
                o_res_valid   = 1'b1;
                w_res.outcome = OC_HDR_BAD;
            end
        end else if (r_stage == ST_HDR1) begin
            if (i_byte == i_cfg.start_second) begin
                n_stage = ST_HDR2;
            end else begin
                n_idx         = '0;
                n_stage       = ST_IDLE;
                o_res_valid   = 1'b1;
                w_res.outcome = OC_HDR_BAD;
            end
        end else if (r_stage != ST_HDR2) begin
            // no header seen: only count
        end else if (w_idx == IDX_W'(3)) begin
            n_dtype = i_byte;
        end else if (r_dtype == i_cfg.dtype_string) begin
            n_idx         = '0;
            n_stage       = ST_IDLE;
            o_res_valid   = 1'b1;
            w_res.outcome = OC_STRING;
        end else if (w_idx == IDX_W'(HDR_BYTES)) begin
            n_len = i_byte;
        end else if (w_done) begin
            n_idx       = '0;
            n_stage     = ST_IDLE;
            o_res_valid = 1'b1;
            if (r_dtype == i_cfg.cmd_dtype) begin
                w_res.command_type = n_pkt[CMD_POS];
                priority if (n_pkt[CMD_POS] == i_cfg.motor_ctype) begin
                    w_res.outcome    = OC_MOTOR;
                    w_res.first_arg  = n_pkt[CMD_POS + 1];
                    w_res.second_arg = n_pkt[CMD_POS + 2];
                    w_res.third_arg  = n_pkt[CMD_POS + 3];
                end else if (n_pkt[CMD_POS] == i_cfg.servo_ctype) begin
                    w_res.outcome    = OC_SERVO;
                    w_res.first_arg  = n_pkt[CMD_POS + 1];
                    w_res.second_arg = n_pkt[CMD_POS + 2];
                    w_res.third_arg  = n_pkt[CMD_POS + 3];
                end else if (n_pkt[CMD_POS] == i_cfg.ctype_lamp) begin
                    w_res.outcome    = OC_LAMP;
                    w_res.first_arg  = n_pkt[CMD_POS + 1];
                    w_res.second_arg = n_pkt[CMD_POS + 2];
                end else begin
                    w_res.outcome = OC_UNKNOWN;
                end
            end else begin
                w_res.outcome = OC_OTHER;
            end
        end else begin
            // payload still arriving: only count
        end
        if (!i_go) begin
            o_res_valid = 1'b0;
        end
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_stage <= ST_IDLE;
            r_dtype <= '0;
            r_len   <= '0;
            for (int k = CMD_POS; k <= ARG_LAST; k++) begin
                r_pkt[k] <= '0;
            end
        end else if (i_go) begin
            r_idx   <= n_idx;
            r_stage <= n_stage;
            r_dtype <= n_dtype;
            r_len   <= n_len;
            for (int k = CMD_POS; k <= ARG_LAST; k++) begin
                r_pkt[k] <= n_pkt[k];
            end
        end
    end

endmodule

// ===== rtl/core/header_length_command_deframer.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Bus          Content
// s_axis    in   8-bit data   one received byte per transfer
// m_axis    out  40-bit data  outcome, command type and three arguments
// cfg       in   write only   seven 8-bit code registers, index 0..6
//
// Each byte passes an input register, one level of frame logic and the result
// register; one byte per cycle is sustained while m_axis does not stall.
// The input register is freed whenever the result register is empty or being
// taken; a stall on m_axis holds the pending byte and blocks s_axis.
// Reset (synchronous, active low) clears flags, config and frame state, not data regs.
// Top level; depends on hlcd_pkg, hlcd_cfg and hlcd_parse.

module header_length_command_deframer
    import hlcd_pkg::*;
#(
    parameter int MAX_PACKET = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] outcome, [10:3] command_type, [18:11] first_arg,
    // [26:19] second_arg, [34:27] third_arg, [39:35] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0]     i_cfg_data
);

    t_cfg              w_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_out_free;
    logic              w_go;
    logic              w_res_valid;
    t_result           w_res;

    hlcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_go          = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    hlcd_parse #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_byte      (r_in_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // advance the result register whenever it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out};

    // a byte waiting behind a stalled result must be held
    a_hold_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending byte lost while result stalled");

    a_res_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_go))
        else $error("result appeared without a consumed byte");

    a_status_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.outcome == OC_OTHER || r_out.outcome == OC_STRING
            || r_out.outcome == OC_HDR_BAD || r_out.outcome == OC_OVERFLOW))
        |-> (m_axis_tdata[OUT_FLD_W-1:3] == '0))
        else $error("status result carries command fields");

    a_lamp_third : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.outcome == OC_LAMP || r_out.outcome == OC_UNKNOWN))
        |-> (r_out.third_arg == '0))
        else $error("lamp or unknown command carries a third argument");

endmodule
